@@ hw/rtl/wps_pkg.sv @@
package wps_pkg;

   localparam int MAX_WAYPOINTS = 16;
   localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);
   localparam int ADDR_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

   localparam int COORD_W   = 32;
   localparam int DIFF_W    = 33;
   localparam int CFG_W     = 31;
   localparam int HEAD_W    = 18;
   localparam int LEFT_W    = 5;
   localparam int ROOT_W    = 32;
   localparam int RAD_W     = 64;
   localparam int QUO_W     = 32;

   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int DIV_STEPS  = RAD_W;

   localparam logic [CFG_W-1:0] STEP_LENGTH_RESET = 31'd3277;
   localparam logic [CFG_W-1:0] MIN_TURN_RESET    = 31'd66;
   localparam logic [16:0]      ONE_Q16           = 17'd65536;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TURN    = 1'b1;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_PUSH = 2'd1;
   localparam logic [1:0] REQ_SET  = 2'd2;

   // saturate a 34-bit signed sum to the 32-bit range
   function automatic logic signed [COORD_W-1:0] sat34(input logic signed [33:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // clamp a heading quotient to one and apply the sign
   function automatic logic signed [HEAD_W-1:0] clamp_heading(input logic [QUO_W-1:0] q,
                                                               input logic neg);
      logic [HEAD_W-1:0] m;
      m = (q > QUO_W'(ONE_Q16)) ? HEAD_W'(ONE_Q16) : q[HEAD_W-1:0];
      return neg ? -m : m;
   endfunction

endpackage

@@ hw/rtl/wps_isqrt.sv @@
module wps_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wps_pkg::RAD_W-1:0]   radicand,
   output logic                        done,
   output logic [wps_pkg::ROOT_W-1:0]  root
);
   import wps_pkg::*;

   localparam int CW = $clog2(SQRT_STEPS);
   localparam int RW = ROOT_W + 3;

   logic          run_ff, done_ff;
   logic [CW-1:0] cnt_ff;
   logic [RAD_W-1:0]  num_ff;
   logic [RW-1:0]     rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [RW-1:0]     rem_sh, trial;
   logic              ge;

   // two radicand bits per step
   assign rem_sh = {rem_ff[RW-3:0], num_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(SQRT_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         num_ff  <= {num_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

@@ hw/rtl/wps_div.sv @@
module wps_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wps_pkg::RAD_W-1:0]   dividend,
   input  logic [wps_pkg::DIFF_W-1:0]  divisor,
   output logic                        done,
   output logic [wps_pkg::QUO_W-1:0]   quotient
);
   import wps_pkg::*;

   localparam int CW = $clog2(DIV_STEPS);

   logic          run_ff, done_ff;
   logic [CW-1:0] cnt_ff;
   logic [RAD_W-1:0]  num_ff;
   logic [DIFF_W-1:0] den_ff;
   logic [DIFF_W-1:0] rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [DIFF_W:0]   rem_sh, diff;
   logic              ge;

   // restoring, one quotient bit per step
   assign rem_sh = {rem_ff, num_ff[RAD_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[RAD_W-2:0], 1'b0};
         rem_ff <= ge ? diff[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ hw/rtl/waypoint_path_stepper_core.sv @@
// push, set position, unused codes and ticks on an empty path: strobe in the cycle after
// the accepting edge, after which the core is idle again and can take a new transaction
// a tick costs one 32-step root per waypoint reached, two 64-step divides for a partial move,
// one more root to measure the net displacement and two more divides for a heading update,
// plus accept, final check and strobe
// one transaction at a time, busy stays high through the strobe; the receiver cannot stall
module waypoint_path_stepper_core (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic signed [wps_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [wps_pkg::COORD_W-1:0]  req_coord_y,
   // result side
   output logic                                rsp_valid,
   output logic signed [wps_pkg::COORD_W-1:0]  rsp_pos_x,
   output logic signed [wps_pkg::COORD_W-1:0]  rsp_pos_y,
   output logic signed [wps_pkg::HEAD_W-1:0]   rsp_heading_x,
   output logic signed [wps_pkg::HEAD_W-1:0]   rsp_heading_y,
   output logic [wps_pkg::LEFT_W-1:0]          rsp_waypoints_left,
   output logic                                rsp_push_dropped,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_wdata
);
   import wps_pkg::*;

   // synchronous reset clears position, heading and path count and restores the
   // register defaults; the waypoint memory is not cleared

   typedef enum logic [21:0] {
      S_IDLE  = 22'h000001,
      S_CHK   = 22'h000002,
      S_RD    = 22'h000004,
      S_DIFF  = 22'h000008,
      S_HDIFF = 22'h000010,
      S_ABS   = 22'h000020,
      S_SQX   = 22'h000040,
      S_SQY   = 22'h000080,
      S_SUM   = 22'h000100,
      S_SQRT  = 22'h000200,
      S_LEN   = 22'h000400,
      S_MX    = 22'h000800,
      S_DVX   = 22'h001000,
      S_WDX   = 22'h002000,
      S_MY    = 22'h004000,
      S_DVY   = 22'h008000,
      S_WDY   = 22'h010000,
      S_HX    = 22'h020000,
      S_WHX   = 22'h040000,
      S_HY    = 22'h080000,
      S_WHY   = 22'h100000,
      S_RESP  = 22'h200000
   } state_type;

   state_type state_ff, state_in;

   // registers and architectural state
   logic [CFG_W-1:0]          step_ff, min_turn_ff;
   logic signed [COORD_W-1:0] pos_x_ff, pos_y_ff, start_x_ff, start_y_ff;
   logic signed [HEAD_W-1:0]  orient_x_ff, orient_y_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      dropped_ff;

   // working registers of one tick
   logic [CFG_W-1:0]          budget_ff;
   logic                      mode_ff;      // high while measuring the net displacement
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff;
   logic [COORD_W-1:0]        absx_ff, absy_ff;
   logic                      shift_ff;
   logic [RAD_W-1:0]          mul_ff, sq_ff;
   logic [DIFF_W-1:0]         len_ff;
   logic [QUO_W-1:0]          qx_ff;

   // waypoint memory
   logic signed [COORD_W-1:0] mem_x [MAX_WAYPOINTS];
   logic signed [COORD_W-1:0] mem_y [MAX_WAYPOINTS];
   logic signed [COORD_W-1:0] rd_x_ff, rd_y_ff;
   logic [CNT_W-1:0]          cnt_m1;
   logic [ADDR_W-1:0]         rd_idx;
   logic                      push_ok;

   // shared units
   logic [COORD_W-1:0]  mul_a, mul_b, ax_s, ay_s, absx_c, absy_c;
   logic [RAD_W-1:0]    mul_p;
   logic                sqrt_start, sqrt_done, div_start, div_done;
   logic [ROOT_W-1:0]   root;
   logic [QUO_W-1:0]    quo;
   logic [RAD_W-1:0]    div_num;
   logic                accept;
   logic signed [33:0]  sum_x, sum_y;
   logic [33:0]         qx_s, qy_s;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign push_ok   = (count_ff < CNT_W'(MAX_WAYPOINTS));
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign rd_idx    = cnt_m1[ADDR_W-1:0];

   // magnitudes of the difference; a full 32-bit magnitude halves both
   assign absx_c = dx_ff[DIFF_W-1] ? COORD_W'(-dx_ff) : COORD_W'(dx_ff);
   assign absy_c = dy_ff[DIFF_W-1] ? COORD_W'(-dy_ff) : COORD_W'(dy_ff);
   assign ax_s   = absx_ff >> shift_ff;
   assign ay_s   = absy_ff >> shift_ff;

   // one multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQX:   begin mul_a = ax_s;    mul_b = ax_s; end
         S_SQY:   begin mul_a = ay_s;    mul_b = ay_s; end
         S_MX:    begin mul_a = absx_ff; mul_b = {1'b0, budget_ff}; end
         S_MY:    begin mul_a = absy_ff; mul_b = {1'b0, budget_ff}; end
         default: begin mul_a = '0;      mul_b = '0; end
      endcase
   end

   // full 64-bit product of the two 32-bit operands
   assign mul_p = mul_a * mul_b;

   assign sqrt_start = (state_ff == S_SUM);
   assign div_start  = (state_ff == S_DVX) || (state_ff == S_DVY) ||
                       (state_ff == S_HX)  || (state_ff == S_HY);

   always_comb begin
      unique case (state_ff)
         S_DVX, S_DVY: div_num = mul_ff;
         S_HX:         div_num = RAD_W'({absx_ff, 16'h0000});
         S_HY:         div_num = RAD_W'({absy_ff, 16'h0000});
         default:      div_num = mul_ff;
      endcase
   end

   wps_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff + mul_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   wps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // partial move: signed quotient added with saturation
   assign qx_s  = dx_ff[DIFF_W-1] ? -{2'b00, qx_ff} : {2'b00, qx_ff};
   assign qy_s  = dy_ff[DIFF_W-1] ? -{2'b00, quo}   : {2'b00, quo};
   assign sum_x = 34'(pos_x_ff) + $signed(qx_s);
   assign sum_y = 34'(pos_y_ff) + $signed(qy_s);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_type == REQ_TICK && count_ff != '0) begin
                  state_in = S_CHK;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_CHK: begin
            if (count_ff != '0 && budget_ff != '0) begin
               state_in = S_RD;
            end else begin
               state_in = S_HDIFF;
            end
         end
         S_RD:    state_in = S_DIFF;
         S_DIFF:  state_in = S_ABS;
         S_HDIFF: state_in = S_ABS;
         S_ABS:   state_in = S_SQX;
         S_SQX:   state_in = S_SQY;
         S_SQY:   state_in = S_SUM;
         S_SUM:   state_in = S_SQRT;
         S_SQRT:  if (sqrt_done) state_in = S_LEN;
         S_LEN: begin
            if (!mode_ff) begin
               state_in = (len_ff <= {2'b00, budget_ff}) ? S_CHK : S_MX;
            end else begin
               state_in = (len_ff > {2'b00, min_turn_ff}) ? S_HX : S_RESP;
            end
         end
         S_MX:    state_in = S_DVX;
         S_DVX:   state_in = S_WDX;
         S_WDX:   if (div_done) state_in = S_MY;
         S_MY:    state_in = S_DVY;
         S_DVY:   state_in = S_WDY;
         S_WDY:   if (div_done) state_in = S_HDIFF;
         S_HX:    state_in = S_WHX;
         S_WHX:   if (div_done) state_in = S_HY;
         S_HY:    state_in = S_WHY;
         S_WHY:   if (div_done) state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         step_ff     <= STEP_LENGTH_RESET;
         min_turn_ff <= MIN_TURN_RESET;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         orient_x_ff <= '0;
         orient_y_ff <= '0;
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_STEP_LENGTH: step_ff     <= csr_wdata[CFG_W-1:0];
               CSR_MIN_TURN:    min_turn_ff <= csr_wdata[CFG_W-1:0];
               default:         ;
            endcase
         end
         if (accept) begin
            dropped_ff <= 1'b0;
            if (req_type == REQ_PUSH) begin
               if (push_ok) begin
                  count_ff <= count_ff + CNT_W'(1);
               end else begin
                  dropped_ff <= 1'b1;
               end
            end else if (req_type == REQ_SET) begin
               pos_x_ff <= req_coord_x;
               pos_y_ff <= req_coord_y;
               count_ff <= '0;
            end
         end
         // waypoint reached: jump onto it and pop
         if (state_ff == S_LEN && !mode_ff && len_ff <= {2'b00, budget_ff}) begin
            pos_x_ff <= rd_x_ff;
            pos_y_ff <= rd_y_ff;
            count_ff <= cnt_m1;
         end
         if (state_ff == S_WDY && div_done) begin
            pos_x_ff <= sat34(sum_x);
            pos_y_ff <= sat34(sum_y);
         end
         if (state_ff == S_WHY && div_done) begin
            orient_x_ff <= clamp_heading(qx_ff, dx_ff[DIFF_W-1]);
            orient_y_ff <= clamp_heading(quo, dy_ff[DIFF_W-1]);
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      mul_ff <= mul_p;
      if (accept) begin
         budget_ff  <= step_ff;
         start_x_ff <= pos_x_ff;
         start_y_ff <= pos_y_ff;
         mode_ff    <= 1'b0;
      end
      unique case (state_ff)
         S_DIFF: begin
            dx_ff <= DIFF_W'(rd_x_ff) - DIFF_W'(pos_x_ff);
            dy_ff <= DIFF_W'(rd_y_ff) - DIFF_W'(pos_y_ff);
         end
         S_HDIFF: begin
            mode_ff <= 1'b1;
            dx_ff   <= DIFF_W'(pos_x_ff) - DIFF_W'(start_x_ff);
            dy_ff   <= DIFF_W'(pos_y_ff) - DIFF_W'(start_y_ff);
         end
         S_ABS: begin
            absx_ff  <= absx_c;
            absy_ff  <= absy_c;
            shift_ff <= absx_c[COORD_W-1] | absy_c[COORD_W-1];
         end
         S_SQY: sq_ff <= mul_ff;
         S_SQRT: begin
            if (sqrt_done) begin
               len_ff <= DIFF_W'(root) << shift_ff;
            end
         end
         S_LEN: begin
            if (!mode_ff && len_ff <= {2'b00, budget_ff}) begin
               budget_ff <= budget_ff - len_ff[CFG_W-1:0];
            end
         end
         S_WDX, S_WHX: begin
            if (div_done) begin
               qx_ff <= quo;
            end
         end
         S_WDY: begin
            if (div_done) begin
               budget_ff <= '0;
            end
         end
         default: ;
      endcase
   end

   // waypoint memory, last entry read every cycle
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_PUSH && push_ok) begin
         mem_x[count_ff[ADDR_W-1:0]] <= req_coord_x;
         mem_y[count_ff[ADDR_W-1:0]] <= req_coord_y;
      end
      rd_x_ff <= mem_x[rd_idx];
      rd_y_ff <= mem_y[rd_idx];
   end

   // result transaction, one strobe cycle
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_pos_x          = pos_x_ff;
   assign rsp_pos_y          = pos_y_ff;
   assign rsp_heading_x      = orient_x_ff;
   assign rsp_heading_y      = orient_y_ff;
   assign rsp_waypoints_left = LEFT_W'(count_ff);
   assign rsp_push_dropped   = dropped_ff;
endmodule
